// ===== src/fdt_pkg.sv =====
package fdt_pkg;

   // ASCII codes
   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_DOT   = 7'h2E;
   localparam logic [6:0] CH_MINUS = 7'h2D;
   localparam logic [6:0] CH_NONE  = 7'h00;

   // scaled magnitude floor(|x|*100) stays below 2^31
   localparam int SCALED_W  = 31;
   // decimal digits of the scaled magnitude
   localparam int DEC_DIGITS = 10;
   localparam int BCD_W      = 4 * DEC_DIGITS;
   // conversion bits handled per pipeline stage
   localparam int DD_STEPS   = 4;
   localparam int DD_STAGES  = (SCALED_W + DD_STEPS - 1) / DD_STEPS;
   // integer digits that can occur at all
   localparam int WHOLE_DIGITS = DEC_DIGITS - 2;

   // binary exponent offsets
   localparam logic signed [8:0] SH_SUBNORMAL = -9'sd149;
   localparam logic signed [8:0] EXP_BIAS_SH  = 9'sd150;

   typedef logic [3:0] nibble_type;

endpackage

// ===== src/float_to_decimal_text.sv =====
// Float to decimal text formatter.
// req channel: one 32-bit word per number, the IEEE single-precision bit
// pattern, accepted when req_valid is high and req_stall is low.
// rsp channel: one ASCII character per word, most significant first:
// optional '-', integer digits, '.', two truncated fraction digits.
// rsp_last_char marks the final character. NaN, infinity or a value too
// large gives a single word with rsp_out_of_range set and char zero.
// Pipeline: a number passes an input register, a scaling multiply, an
// exponent shift and eight binary-to-decimal stages (four bits each)
// before the serializer loads it.
// Throughput: the serializer sends one character per cycle unless
// stalled, 1 to 12 per number, after loading the number while idle; the
// pipeline in front keeps further numbers moving while one is being sent.
// Reset (synchronous, active high) empties every stage and the output.
// When the receiver stalls, the output word holds and the stages fill up,
// then req_stall rises.
module float_to_decimal_text #(
   parameter int MAX_INT_DIGITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_text_char,
   output logic        rsp_last_char,
   output logic        rsp_out_of_range
);
   import fdt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SIGN, ST_INT, ST_DOT, ST_FRAC1, ST_FRAC0, ST_ERR
   } ser_state_type;

   // stage 1: input word
   logic        v1_ff, v1_in;
   logic [31:0] bits1_ff, bits1_in;
   // stage 2: scaled significand
   logic                v2_ff, v2_in;
   logic [SCALED_W-1:0] prod2_ff, prod2_in;
   logic signed [8:0]   sh2_ff, sh2_in;
   logic                err2_ff, err2_in, neg2_ff, neg2_in;
   // stage 3: scaled magnitude
   logic                v3_ff, v3_in;
   logic [SCALED_W-1:0] t3_ff, t3_in;
   logic                err3_ff, err3_in, neg3_ff, neg3_in;
   // conversion stages
   logic                vd_ff  [DD_STAGES], vd_in  [DD_STAGES];
   logic [BCD_W-1:0]    bcd_ff [DD_STAGES], bcd_in [DD_STAGES];
   logic [SCALED_W-1:0] bin_ff [DD_STAGES], bin_in [DD_STAGES];
   logic                errd_ff[DD_STAGES], errd_in[DD_STAGES];
   logic                negd_ff[DD_STAGES], negd_in[DD_STAGES];
   logic                rdyd   [DD_STAGES];
   // serializer
   ser_state_type state_ff, state_in;
   nibble_type    dig_ff [DEC_DIGITS], dig_in [DEC_DIGITS];
   logic [3:0]    ptr_ff, ptr_in;
   logic          has_int_ff, has_int_in;
   // output word
   logic       rv_ff, rv_in, rl_ff, rl_in, re_ff, re_in;
   logic [6:0] rc_ff, rc_in;

   logic rdy1, rdy2, rdy3, load, omove;

   // one shift-add-3 step of the binary to decimal conversion
   function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b,
                                                 input logic bit_in);
      logic [BCD_W-1:0] a;
      a = b;
      for (int n = 0; n < DEC_DIGITS; n++) begin
         if (a[4*n +: 4] >= 4'd5) begin
            a[4*n +: 4] = a[4*n +: 4] + 4'd3;
         end
      end
      return {a[BCD_W-2:0], bit_in};
   endfunction

   assign load  = (state_ff == ST_IDLE);
   assign omove = !rv_ff || !rsp_stall;

   // ready chain, back to front
   always_comb begin
      rdyd[DD_STAGES-1] = !vd_ff[DD_STAGES-1] || load;
      for (int k = DD_STAGES - 2; k >= 0; k--) begin
         rdyd[k] = !vd_ff[k] || rdyd[k+1];
      end
      rdy3 = !v3_ff || rdyd[0];
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
   end
   assign req_stall = !rdy1;

   // stages 1 to 3: capture, scale by 100, apply exponent
   always_comb begin
      logic [7:0]  expo;
      logic [23:0] mant;
      logic [62:0] wide;
      logic [8:0]  rs;
      v1_in    = v1_ff;
      bits1_in = bits1_ff;
      if (rdy1) begin
         v1_in    = req_valid;
         bits1_in = req_value_bits;
      end

      expo     = bits1_ff[30:23];
      mant     = {(expo != 8'd0), bits1_ff[22:0]};
      v2_in    = v2_ff;
      prod2_in = prod2_ff;
      sh2_in   = sh2_ff;
      err2_in  = err2_ff;
      neg2_in  = neg2_ff;
      if (rdy2) begin
         v2_in    = v1_ff;
         prod2_in = {7'd0, mant} * 31'd100;
         sh2_in   = (expo == 8'd0) ? SH_SUBNORMAL
                                   : $signed({1'b0, expo}) - EXP_BIAS_SH;
         err2_in  = (expo == 8'hFF);
         neg2_in  = bits1_ff[31] && (bits1_ff[30:0] != 31'd0);
      end

      wide    = {32'd0, prod2_ff} << sh2_ff[4:0];
      rs      = 9'(-sh2_ff);
      v3_in   = v3_ff;
      t3_in   = t3_ff;
      err3_in = err3_ff;
      neg3_in = neg3_ff;
      if (rdy3) begin
         v3_in   = v2_ff;
         neg3_in = neg2_ff;
         if (!sh2_ff[8]) begin
            err3_in = err2_ff || (sh2_ff >= 9'sd32) || (wide[62:31] != 32'd0);
            t3_in   = wide[30:0];
         end else begin
            err3_in = err2_ff;
            t3_in   = (rs >= 9'd31) ? '0 : (prod2_ff >> rs[4:0]);
         end
      end
   end

   // conversion pipeline, DD_STEPS bits a stage
   always_comb begin
      logic [BCD_W-1:0]    b;
      logic [SCALED_W-1:0] r;
      for (int k = 0; k < DD_STAGES; k++) begin
         vd_in[k]   = vd_ff[k];
         bcd_in[k]  = bcd_ff[k];
         bin_in[k]  = bin_ff[k];
         errd_in[k] = errd_ff[k];
         negd_in[k] = negd_ff[k];
         if (k == 0) begin
            b = '0;
            r = t3_ff;
         end else begin
            b = bcd_ff[k-1];
            r = bin_ff[k-1];
         end
         for (int j = 0; j < DD_STEPS; j++) begin
            if (k * DD_STEPS + j < SCALED_W) begin
               b = dd_step(b, r[SCALED_W-1]);
               r = {r[SCALED_W-2:0], 1'b0};
            end
         end
         if (rdyd[k]) begin
            bcd_in[k] = b;
            bin_in[k] = r;
            if (k == 0) begin
               vd_in[k]   = v3_ff;
               errd_in[k] = err3_ff;
               negd_in[k] = neg3_ff;
            end else begin
               vd_in[k]   = vd_ff[k-1];
               errd_in[k] = errd_ff[k-1];
               negd_in[k] = negd_ff[k-1];
            end
         end
      end
   end

   // serializer and output word
   always_comb begin
      logic [3:0] ndig;
      ndig = 4'd0;
      for (int i = 0; i < WHOLE_DIGITS; i++) begin
         if (bcd_ff[DD_STAGES-1][4*(i+2) +: 4] != 4'd0) begin
            ndig = 4'(i + 1);
         end
      end
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      has_int_in = has_int_ff;
      for (int n = 0; n < DEC_DIGITS; n++) begin
         dig_in[n] = dig_ff[n];
      end
      rv_in = rv_ff;
      rc_in = rc_ff;
      rl_in = rl_ff;
      re_in = re_ff;
      if (omove) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (vd_ff[DD_STAGES-1]) begin
               for (int n = 0; n < DEC_DIGITS; n++) begin
                  dig_in[n] = bcd_ff[DD_STAGES-1][4*n +: 4];
               end
               ptr_in     = ndig + 4'd1;
               has_int_in = (ndig != 4'd0);
               if (errd_ff[DD_STAGES-1] || (32'(ndig) > 32'(MAX_INT_DIGITS))) begin
                  state_in = ST_ERR;
               end else if (negd_ff[DD_STAGES-1]) begin
                  state_in = ST_SIGN;
               end else if (ndig != 4'd0) begin
                  state_in = ST_INT;
               end else begin
                  state_in = ST_DOT;
               end
            end
         end
         ST_ERR: begin
            if (omove) begin
               rv_in = 1'b1; rc_in = CH_NONE; rl_in = 1'b1; re_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SIGN: begin
            if (omove) begin
               rv_in = 1'b1; rc_in = CH_MINUS; rl_in = 1'b0; re_in = 1'b0;
               state_in = has_int_ff ? ST_INT : ST_DOT;
            end
         end
         ST_INT: begin
            if (omove) begin
               rv_in = 1'b1; rc_in = CH_ZERO + {3'd0, dig_ff[ptr_ff]};
               rl_in = 1'b0; re_in = 1'b0;
               ptr_in = ptr_ff - 4'd1;
               if (ptr_ff == 4'd2) begin
                  state_in = ST_DOT;
               end
            end
         end
         ST_DOT: begin
            if (omove) begin
               rv_in = 1'b1; rc_in = CH_DOT; rl_in = 1'b0; re_in = 1'b0;
               state_in = ST_FRAC1;
            end
         end
         ST_FRAC1: begin
            if (omove) begin
               rv_in = 1'b1; rc_in = CH_ZERO + {3'd0, dig_ff[1]};
               rl_in = 1'b0; re_in = 1'b0;
               state_in = ST_FRAC0;
            end
         end
         ST_FRAC0: begin
            if (omove) begin
               rv_in = 1'b1; rc_in = CH_ZERO + {3'd0, dig_ff[0]};
               rl_in = 1'b1; re_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // all registers
   always_ff @(posedge clock) begin
      bits1_ff   <= bits1_in;
      prod2_ff   <= prod2_in;
      sh2_ff     <= sh2_in;
      err2_ff    <= err2_in;
      neg2_ff    <= neg2_in;
      t3_ff      <= t3_in;
      err3_ff    <= err3_in;
      neg3_ff    <= neg3_in;
      ptr_ff     <= ptr_in;
      has_int_ff <= has_int_in;
      rc_ff      <= rc_in;
      rl_ff      <= rl_in;
      re_ff      <= re_in;
      for (int k = 0; k < DD_STAGES; k++) begin
         bcd_ff[k]  <= bcd_in[k];
         bin_ff[k]  <= bin_in[k];
         errd_ff[k] <= errd_in[k];
         negd_ff[k] <= negd_in[k];
      end
      for (int n = 0; n < DEC_DIGITS; n++) begin
         dig_ff[n] <= dig_in[n];
      end
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         rv_ff    <= 1'b0;
         state_ff <= ST_IDLE;
         for (int k = 0; k < DD_STAGES; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         rv_ff    <= rv_in;
         state_ff <= state_in;
         for (int k = 0; k < DD_STAGES; k++) begin
            vd_ff[k] <= vd_in[k];
         end
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_text_char    = rc_ff;
   assign rsp_last_char    = rl_ff;
   assign rsp_out_of_range = re_ff;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fdt_pkg::*;

   localparam int INT_DIGITS_MAX = 8;

   typedef struct packed {
      logic [6:0] text_char;
      logic       last_char;
      logic       out_of_range;
   } char_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_value_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [6:0]  rsp_text_char;
   logic        rsp_last_char;
   logic        rsp_out_of_range;

   float_to_decimal_text #(.MAX_INT_DIGITS(INT_DIGITS_MAX)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_value_bits(req_value_bits),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_text_char(rsp_text_char),
      .rsp_last_char(rsp_last_char), .rsp_out_of_range(rsp_out_of_range)
   );

   always #10 clock = ~clock;

   logic [31:0]   pending_values[$];
   char_word_type expected_chars[$];
   int            error_count = 0;
   bit            stim_done = 0;
   int            hold_cycles = 0;
   int            long_hold_left = 0;

   // short gaps mostly, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // expected text of one float, exact fixed point floor(|x|*100)
   task automatic format_float(input logic [31:0] bits);
      logic [7:0]  expo;
      logic [63:0] prod;
      int          shift;
      bit          bad;
      int unsigned whole, frac;
      int          ndig;
      logic [3:0]  digs[10];
      bad = 0;
      ndig = 0;
      expo = bits[30:23];
      if (expo == 8'hFF) bad = 1;
      else begin
         if (expo == 0) begin
            prod = 64'(bits[22:0]) * 100;
            shift = -149;
         end else begin
            prod = 64'({1'b1, bits[22:0]}) * 100;
            shift = int'(expo) - 150;
         end
         if (shift >= 32) bad = 1;
         else if (shift >= 0) prod = prod << shift;
         else if (-shift >= 63) prod = 0;
         else prod = prod >> (-shift);
         if (!bad && prod >= 64'h8000_0000) bad = 1;
      end
      if (!bad) begin
         whole = 32'(prod / 100);
         frac = 32'(prod % 100);
         while (whole > 0 && ndig < 10) begin
            digs[ndig] = 4'(whole % 10);
            whole = whole / 10;
            ndig++;
         end
         if (ndig > INT_DIGITS_MAX) bad = 1;
      end
      if (bad) begin
         expected_chars.push_back(char_word_type'{CH_NONE, 1'b1, 1'b1});
      end else begin
         if (bits[31] && bits[30:0] != 0)
            expected_chars.push_back(char_word_type'{CH_MINUS, 1'b0, 1'b0});
         for (int i = ndig - 1; i >= 0; i--)
            expected_chars.push_back(char_word_type'{CH_ZERO + 7'(digs[i]), 1'b0, 1'b0});
         expected_chars.push_back(char_word_type'{CH_DOT, 1'b0, 1'b0});
         expected_chars.push_back(char_word_type'{CH_ZERO + 7'(frac / 10), 1'b0, 1'b0});
         expected_chars.push_back(char_word_type'{CH_ZERO + 7'(frac % 10), 1'b1, 1'b0});
      end
   endtask

   // random float: mostly formattable exponents, some anywhere
   function automatic logic [31:0] random_float();
      logic [31:0] v;
      int r;
      v = $urandom;
      r = $urandom_range(99);
      if (r < 60) v[30:23] = 8'($urandom_range(152, 110));
      else if (r < 70) v[30:23] = 8'($urandom_range(160, 150));
      else if (r < 75) v[30:23] = 8'h00;
      else if (r < 78) v[30:23] = 8'hFF;
      return v;
   endfunction

   // fill the item queue
   initial begin
      logic [31:0] directed[$];
      directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F00_0000, 32'hBA83_126F,
                   32'h3C23_D70A, 32'h3F80_0000, 32'hBF80_0000, 32'h4B18_967F,
                   32'h4CBE_BC20, 32'h4E00_0000, 32'h4B7F_FFFF, 32'h7F80_0000,
                   32'hFF80_0000, 32'h7FC0_0001, 32'h7FFF_FFFF, 32'h0000_0001,
                   32'h807F_FFFF, 32'h3F7F_FFFF, 32'hFFFF_FFFF, 32'h3DCC_CCCD,
                   32'h4B98_9680, 32'h4B98_967F, 32'hC2C8_0000, 32'h4D80_0000};
      foreach (directed[i]) pending_values.push_back(directed[i]);
      repeat (420) pending_values.push_back(random_float());
   end

   // input driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
         // hold word
      end else begin
         if (req_valid) begin
            format_float(req_value_bits);
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_values.size() > 0) begin
            req_value_bits <= pending_values.pop_front();
            req_valid <= 1'b1;
            send_gap <= gap_length();
         end else begin
            req_valid <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   // receiver: random stall, one long hold-off early in the run
   int accepted_chars = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            char_word_type exp_w;
            accepted_chars <= accepted_chars + 1;
            if (expected_chars.size() == 0) begin
               $error("unexpected char word %h", rsp_text_char);
               error_count++;
            end else begin
               exp_w = expected_chars.pop_front();
               if (rsp_text_char !== exp_w.text_char) begin
                  $error("text_char exp %h got %h", exp_w.text_char, rsp_text_char);
                  error_count++;
               end
               if (rsp_last_char !== exp_w.last_char) begin
                  $error("last_char exp %b got %b", exp_w.last_char, rsp_last_char);
                  error_count++;
               end
               if (rsp_out_of_range !== exp_w.out_of_range) begin
                  $error("out_of_range exp %b got %b", exp_w.out_of_range,
                         rsp_out_of_range);
                  error_count++;
               end
            end
         end
         if (long_hold_left > 0) begin
            long_hold_left <= long_hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (accepted_chars == 300 && hold_cycles == 0) begin
            hold_cycles <= 1;
            long_hold_left <= 400;
            rsp_stall <= 1'b1;
         end else if (hold_cycles > 0 && hold_cycles < 1000000) begin
            hold_cycles <= hold_cycles + 1;
            rsp_stall <= (gap_length() != 0);
         end else begin
            if (accepted_chars > 300) hold_cycles <= 1;
            rsp_stall <= ($urandom_range(99) < 10) ? 1'b1 : ((gap_length() > 3));
         end
      end
   end

   // reset, then wait for drain
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && !req_valid && expected_chars.size() == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_chars.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // run limit
   initial begin
      #(20ns * 200000);
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
src/fdt_pkg.sv
src/float_to_decimal_text.sv
verif/tb_top.sv
